FILE: hdl/dms_pkg.sv
package dms_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DEPTH_W     = 16;
   localparam int COLOR_W     = 8;
   localparam int RECIP_W     = 24;
   localparam int CENTER_W    = 11;
   localparam int SIZE_W      = 11;
   localparam int LIMIT_W     = 32;
   localparam int INDEX_W     = 20;
   localparam int POS_W       = 32;
   localparam int PROD_W      = DEPTH_W + RECIP_W;
   localparam int LANE_W      = 32;
   localparam int SQ_W        = 2 * POS_W;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [INDEX_W-1:0] index_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEPTH_UNIT    = 3'd0,
      CSR_FOCAL_X_RECIP = 3'd1,
      CSR_FOCAL_Y_RECIP = 3'd2,
      CSR_CENTER_X      = 3'd3,
      CSR_CENTER_Y      = 3'd4,
      CSR_EDGE_LIMIT    = 3'd5,
      CSR_IMAGE_WIDTH   = 3'd6,
      CSR_IMAGE_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RECIP_W-1:0]  depth_unit;
      logic [RECIP_W-1:0]  focal_x_recip;
      logic [RECIP_W-1:0]  focal_y_recip;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [LIMIT_W-1:0]  edge_limit_squared;
      logic [SIZE_W-1:0]   image_width;
      logic [SIZE_W-1:0]   image_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      depth_unit:         24'd3355,
      focal_x_recip:      24'd31957,
      focal_y_recip:      24'd31957,
      center_x:           11'd639,
      center_y:           11'd479,
      edge_limit_squared: 32'd655,
      image_width:        11'd640,
      image_height:       11'd480
   };

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_FACE   = 1'b1;

   // Magnitude bounds for saturating a coordinate to 32 signed bits.
   localparam logic [63:0] NEG_MAG_LIMIT = 64'h0000_0000_8000_0000;
   localparam logic [63:0] POS_MAG_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [POS_W-1:0] POS_MOST_NEG = 32'h8000_0000;
   localparam logic [POS_W-1:0] POS_MOST_POS = 32'h7FFF_FFFF;

   // Edges checked for the two faces of a grid cell.
   localparam int EDGE_CNT_W = 3;
   localparam logic [EDGE_CNT_W-1:0] EDGE_UL_UP  = 3'd0;
   localparam logic [EDGE_CNT_W-1:0] EDGE_UL_LF  = 3'd1;
   localparam logic [EDGE_CNT_W-1:0] EDGE_UP_LF  = 3'd2;
   localparam logic [EDGE_CNT_W-1:0] EDGE_UP_CUR = 3'd3;
   localparam logic [EDGE_CNT_W-1:0] EDGE_LF_CUR = 3'd4;
   localparam int EDGE_COUNT = 5;
   // Issue cycles plus the two pipeline stages behind them.
   localparam logic [EDGE_CNT_W-1:0] EDGE_LAST_CYCLE = 3'd6;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_B,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_SUM,
      BK_EDGE,
      BK_VERTEX,
      BK_FACE_A,
      BK_FACE_B
   } back_state_type;

endpackage

FILE: hdl/dms_if.sv
interface dms_req_if;
   logic                         valid;
   logic                         ready;
   logic [dms_pkg::DEPTH_W-1:0]  depth;
   logic [dms_pkg::COLOR_W-1:0]  red;
   logic [dms_pkg::COLOR_W-1:0]  green;
   logic [dms_pkg::COLOR_W-1:0]  blue;

   modport source (output valid, depth, red, green, blue, input ready);
   modport sink (input valid, depth, red, green, blue, output ready);
endinterface

interface dms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic                               vertex_ok;
   logic signed [dms_pkg::POS_W-1:0]   pos_x;
   logic signed [dms_pkg::POS_W-1:0]   pos_y;
   logic signed [dms_pkg::POS_W-1:0]   pos_z;
   logic [dms_pkg::COLOR_W-1:0]        out_red;
   logic [dms_pkg::COLOR_W-1:0]        out_green;
   logic [dms_pkg::COLOR_W-1:0]        out_blue;
   logic [dms_pkg::INDEX_W-1:0]        corner_a;
   logic [dms_pkg::INDEX_W-1:0]        corner_b;
   logic [dms_pkg::INDEX_W-1:0]        corner_c;
   logic                               last_result;

   modport source (output valid, kind, vertex_ok, pos_x, pos_y, pos_z, out_red, out_green,
                   out_blue, corner_a, corner_b, corner_c, last_result, input ready);
   modport sink (input valid, kind, vertex_ok, pos_x, pos_y, pos_z, out_red, out_green,
                 out_blue, corner_a, corner_b, corner_c, last_result, output ready);
endinterface

FILE: hdl/dms_front.sv
module dms_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int ROW_W  = $clog2(MAX_HEIGHT),
   localparam int MAG_W0 = (COL_W > ROW_W ? COL_W : ROW_W) + 1,
   localparam int MAG_W  = MAG_W0 > dms_pkg::CENTER_W ? MAG_W0 : dms_pkg::CENTER_W,
   localparam int ITEM_W = dms_pkg::DEPTH_W + 3 * dms_pkg::COLOR_W + COL_W
                           + 2 * (MAG_W + 1) + 4 * dms_pkg::INDEX_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   dms_req_if.sink            req_bus,
   input  dms_pkg::cfg_type   cfg,
   input  logic               queue_full,
   output logic               push,
   output logic [ITEM_W-1:0]  push_data
);

   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   int               w_full;
   int               h_full;
   logic [WID_W-1:0] w;
   logic [HGT_W-1:0] h;

   logic                     accept;
   logic [ROW_W+WID_W-1:0]   row_base;
   dms_pkg::index_type       idx, ia, ib, ic;
   logic [MAG_W-1:0]         twice_col, twice_row, cx, cy, mag_x, mag_y;
   logic                     pos_x, pos_y, closes_quad;
   logic [WID_W-1:0]         col_inc;
   logic [HGT_W-1:0]         row_inc, row_nx;
   logic                     col_wrap;

   // Frame size in use, at least 2 by 2 and clamped to MAX_WIDTH by MAX_HEIGHT.
   always_comb begin
      if (cfg.image_width < 11'd2) begin
         w_full = 2;
      end else if (int'(cfg.image_width) > MAX_WIDTH) begin
         w_full = MAX_WIDTH;
      end else begin
         w_full = int'(cfg.image_width);
      end
      if (cfg.image_height < 11'd2) begin
         h_full = 2;
      end else if (int'(cfg.image_height) > MAX_HEIGHT) begin
         h_full = MAX_HEIGHT;
      end else begin
         h_full = int'(cfg.image_height);
      end
   end

   assign w = WID_W'(w_full);
   assign h = HGT_W'(h_full);

   assign req_bus.ready = ~queue_full;
   assign accept        = req_bus.valid & ~queue_full;

   // Vertex index and the indices of the cell corners, all modulo the index width.
   assign row_base    = row_ff * w;
   assign idx         = dms_pkg::index_type'(row_base) + dms_pkg::index_type'(col_ff);
   assign ib          = idx - dms_pkg::index_type'(w);
   assign ia          = ib - dms_pkg::index_type'(1);
   assign ic          = idx - dms_pkg::index_type'(1);
   assign closes_quad = (row_ff != '0) && (col_ff != '0);

   // Pixel offsets from the principal point, in half pixels, as sign and magnitude.
   assign twice_col = MAG_W'({col_ff, 1'b0});
   assign twice_row = MAG_W'({row_ff, 1'b0});
   assign cx        = MAG_W'(cfg.center_x);
   assign cy        = MAG_W'(cfg.center_y);
   assign pos_x     = twice_col > cx;
   assign pos_y     = twice_row > cy;
   assign mag_x     = pos_x ? twice_col - cx : cx - twice_col;
   assign mag_y     = pos_y ? twice_row - cy : cy - twice_row;

   assign col_inc  = WID_W'(col_ff) + WID_W'(1);
   assign col_wrap = col_inc >= w;
   assign row_inc  = HGT_W'(row_ff) + HGT_W'(1);
   assign row_nx   = col_wrap ? row_inc : HGT_W'(row_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_wrap ? '0 : COL_W'(col_inc);
         row_in = (row_nx >= h) ? '0 : ROW_W'(row_nx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign push      = accept;
   assign push_data = {req_bus.depth, req_bus.red, req_bus.green, req_bus.blue, col_ff,
                       pos_x, mag_x, pos_y, mag_y, idx, ia, ib, ic, closes_quad};

endmodule

FILE: hdl/dms_queue.sv
module dms_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] head
);

   localparam int PTR_W = $clog2(dms_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(dms_pkg::QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [dms_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == CNT_W'(dms_pkg::QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(dms_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(dms_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/dms_back.sv
module dms_back #(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int COORD_FRAC_BITS = 16,
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int ROW_W  = $clog2(MAX_HEIGHT),
   localparam int MAG_W0 = (COL_W > ROW_W ? COL_W : ROW_W) + 1,
   localparam int MAG_W  = MAG_W0 > dms_pkg::CENTER_W ? MAG_W0 : dms_pkg::CENTER_W,
   localparam int ITEM_W = dms_pkg::DEPTH_W + 3 * dms_pkg::COLOR_W + COL_W
                           + 2 * (MAG_W + 1) + 4 * dms_pkg::INDEX_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  dms_pkg::cfg_type   cfg,
   input  logic               queue_valid,
   input  logic [ITEM_W-1:0]  queue_head,
   output logic               queue_pop,
   dms_rsp_if.source          rsp_bus
);

   localparam int A_W    = MAG_W + dms_pkg::DEPTH_W;
   localparam int B_W    = A_W + dms_pkg::RECIP_W;
   localparam int L_W    = dms_pkg::LANE_W + dms_pkg::RECIP_W;
   localparam int C_W    = B_W + dms_pkg::RECIP_W;
   localparam int LAT_SH = 49 - COORD_FRAC_BITS;
   localparam int Z_SH   = 24 - COORD_FRAC_BITS;
   localparam int LIM_SH = 2 * COORD_FRAC_BITS - 16;
   localparam int ROW_ENTRY_W = 3 * dms_pkg::POS_W + 1;

   // Queue head fields, in the order the front packs them.
   logic [dms_pkg::DEPTH_W-1:0] h_depth;
   logic [dms_pkg::COLOR_W-1:0] h_red, h_green, h_blue;
   logic [COL_W-1:0]            h_col;
   logic                        h_pos_x, h_pos_y, h_cell;
   logic [MAG_W-1:0]            h_mag_x, h_mag_y;
   dms_pkg::index_type          h_idx, h_ia, h_ib, h_ic;

   assign {h_depth, h_red, h_green, h_blue, h_col, h_pos_x, h_mag_x, h_pos_y, h_mag_y,
           h_idx, h_ia, h_ib, h_ic, h_cell} = queue_head;

   dms_pkg::back_state_type state_ff, state_in;

   logic [3*dms_pkg::COLOR_W-1:0] it_rgb_ff;
   logic [COL_W-1:0]              it_col_ff;
   logic                          it_ok_ff, it_cell_ff, it_pos_x_ff, it_pos_y_ff;
   dms_pkg::index_type            it_idx_ff, it_ia_ff, it_ib_ff, it_ic_ff;

   logic [dms_pkg::PROD_W-1:0] p_ff;
   logic [A_W-1:0]             ax_ff, ay_ff;
   logic [B_W-1:0]             bx_ff, by_ff;
   logic [L_W-1:0]             lx_ff, ly_ff, hx_ff, hy_ff;
   logic [dms_pkg::LANE_W-1:0] opx, opy;
   logic [L_W-1:0]             mx, my;
   logic [C_W-1:0]             sum_x, sum_y;
   logic [63:0]                mag_x64, mag_y64, mag_z64;
   logic [dms_pkg::POS_W-1:0]  lat_x, lat_y, dep_z;

   logic signed [dms_pkg::POS_W-1:0] cur_ff [3];
   logic signed [dms_pkg::POS_W-1:0] ul_ff [3];
   logic signed [dms_pkg::POS_W-1:0] lf_ff [3];
   logic signed [dms_pkg::POS_W-1:0] up [3];
   logic                             ul_ok_ff, lf_ok_ff, up_ok;

   logic [ROW_ENTRY_W-1:0] row_mem [MAX_WIDTH];
   logic [ROW_ENTRY_W-1:0] row_rd_ff;

   logic [dms_pkg::EDGE_CNT_W-1:0] edge_cnt_ff, edge_cnt_in;
   logic signed [dms_pkg::POS_W-1:0] ep [3];
   logic signed [dms_pkg::POS_W-1:0] eq [3];
   logic [dms_pkg::POS_W-1:0]      e1_ad_ff [3];
   logic [dms_pkg::SQ_W-1:0]       e2_sq_ff [3];
   logic                           e1_v_ff, e2_v_ff;
   logic [dms_pkg::EDGE_CNT_W-1:0] e1_id_ff, e2_id_ff;
   logic [dms_pkg::EDGE_COUNT-1:0] good_ff;
   logic [dms_pkg::SQ_W+1:0]       edge_sum;
   logic [dms_pkg::SQ_W-1:0]       limit;

   logic face_a, face_b, out_free;
   logic edge_issue, emit, item_done;

   logic                             rsp_valid_ff, rsp_kind_ff, rsp_ok_ff, rsp_last_ff;
   logic signed [dms_pkg::POS_W-1:0] rsp_pos_ff [3];
   logic [3*dms_pkg::COLOR_W-1:0]    rsp_rgb_ff;
   dms_pkg::index_type               rsp_a_ff, rsp_b_ff, rsp_c_ff;

   assign up[0] = row_rd_ff[3*dms_pkg::POS_W-1:2*dms_pkg::POS_W];
   assign up[1] = row_rd_ff[2*dms_pkg::POS_W-1:dms_pkg::POS_W];
   assign up[2] = row_rd_ff[dms_pkg::POS_W-1:0];
   assign up_ok = row_rd_ff[3*dms_pkg::POS_W];

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   assign face_a = it_cell_ff & ul_ok_ff & up_ok & lf_ok_ff
                   & good_ff[dms_pkg::EDGE_UL_UP] & good_ff[dms_pkg::EDGE_UL_LF]
                   & good_ff[dms_pkg::EDGE_UP_LF];
   assign face_b = it_cell_ff & up_ok & lf_ok_ff & it_ok_ff
                   & good_ff[dms_pkg::EDGE_UP_LF] & good_ff[dms_pkg::EDGE_UP_CUR]
                   & good_ff[dms_pkg::EDGE_LF_CUR];

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dms_pkg::BK_IDLE: begin
            if (queue_valid) begin
               state_in = dms_pkg::BK_MUL_B;
            end
         end
         dms_pkg::BK_MUL_B:  state_in = dms_pkg::BK_MUL_LO;
         dms_pkg::BK_MUL_LO: state_in = dms_pkg::BK_MUL_HI;
         dms_pkg::BK_MUL_HI: state_in = dms_pkg::BK_SUM;
         dms_pkg::BK_SUM:    state_in = dms_pkg::BK_EDGE;
         dms_pkg::BK_EDGE: begin
            if (edge_cnt_ff == dms_pkg::EDGE_LAST_CYCLE) begin
               state_in = dms_pkg::BK_VERTEX;
            end
         end
         dms_pkg::BK_VERTEX: begin
            if (out_free) begin
               state_in = dms_pkg::BK_FACE_A;
            end
         end
         dms_pkg::BK_FACE_A: begin
            if (!face_a || out_free) begin
               state_in = dms_pkg::BK_FACE_B;
            end
         end
         dms_pkg::BK_FACE_B: begin
            if (!face_b || out_free) begin
               state_in = dms_pkg::BK_IDLE;
            end
         end
         default: state_in = dms_pkg::BK_IDLE;
      endcase
   end

   // Sequencer: strobes.
   always_comb begin
      queue_pop  = 1'b0;
      edge_issue = 1'b0;
      emit       = 1'b0;
      item_done  = 1'b0;
      case (state_ff)
         dms_pkg::BK_IDLE:   queue_pop = queue_valid;
         dms_pkg::BK_EDGE:   edge_issue = edge_cnt_ff < dms_pkg::EDGE_CNT_W'(dms_pkg::EDGE_COUNT);
         dms_pkg::BK_VERTEX: emit = out_free;
         dms_pkg::BK_FACE_A: emit = face_a & out_free;
         dms_pkg::BK_FACE_B: begin
            emit      = face_b & out_free;
            item_done = ~face_b | out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      edge_cnt_in = edge_cnt_ff;
      if (state_ff == dms_pkg::BK_SUM) begin
         edge_cnt_in = '0;
      end else if (state_ff == dms_pkg::BK_EDGE) begin
         edge_cnt_in = edge_cnt_ff + dms_pkg::EDGE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dms_pkg::BK_IDLE;
         edge_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         edge_cnt_ff <= edge_cnt_in;
      end
   end

   // Item capture, first multiply step and the row store read; the row store write when an item is done.
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         it_rgb_ff   <= {h_red, h_green, h_blue};
         it_col_ff   <= h_col;
         it_ok_ff    <= h_depth != '0;
         it_cell_ff  <= h_cell;
         it_pos_x_ff <= h_pos_x;
         it_pos_y_ff <= h_pos_y;
         it_idx_ff   <= h_idx;
         it_ia_ff    <= h_ia;
         it_ib_ff    <= h_ib;
         it_ic_ff    <= h_ic;
         p_ff        <= h_depth * cfg.depth_unit;
         ax_ff       <= h_mag_x * h_depth;
         ay_ff       <= h_mag_y * h_depth;
         row_rd_ff   <= row_mem[h_col];
      end
      if (item_done) begin
         row_mem[it_col_ff] <= {it_ok_ff, cur_ff[0], cur_ff[1], cur_ff[2]};
      end
   end

   // The remaining steps; each lane multiplier takes the low and then the high half of B.
   assign opx = (state_ff == dms_pkg::BK_MUL_LO) ? bx_ff[dms_pkg::LANE_W-1:0]
                : dms_pkg::LANE_W'(bx_ff >> dms_pkg::LANE_W);
   assign opy = (state_ff == dms_pkg::BK_MUL_LO) ? by_ff[dms_pkg::LANE_W-1:0]
                : dms_pkg::LANE_W'(by_ff >> dms_pkg::LANE_W);
   assign mx  = opx * cfg.depth_unit;
   assign my  = opy * cfg.depth_unit;

   always_ff @(posedge clock) begin
      if (state_ff == dms_pkg::BK_MUL_B) begin
         bx_ff <= ax_ff * cfg.focal_x_recip;
         by_ff <= ay_ff * cfg.focal_y_recip;
      end
      if (state_ff == dms_pkg::BK_MUL_LO) begin
         lx_ff <= mx;
         ly_ff <= my;
      end
      if (state_ff == dms_pkg::BK_MUL_HI) begin
         hx_ff <= mx;
         hy_ff <= my;
      end
   end

   assign sum_x   = C_W'({hx_ff, {dms_pkg::LANE_W{1'b0}}}) + C_W'(lx_ff);
   assign sum_y   = C_W'({hy_ff, {dms_pkg::LANE_W{1'b0}}}) + C_W'(ly_ff);
   assign mag_x64 = 64'(sum_x[C_W-1:LAT_SH]);
   assign mag_y64 = 64'(sum_y[C_W-1:LAT_SH]);
   assign mag_z64 = 64'(p_ff[dms_pkg::PROD_W-1:Z_SH]);

   // A positive offset gives a negative output coordinate, and the other way round.
   always_comb begin
      if (it_pos_x_ff) begin
         lat_x = (mag_x64 > dms_pkg::NEG_MAG_LIMIT) ? dms_pkg::POS_MOST_NEG
                 : dms_pkg::POS_W'(64'd0 - mag_x64);
      end else begin
         lat_x = (mag_x64 > dms_pkg::POS_MAG_LIMIT) ? dms_pkg::POS_MOST_POS
                 : dms_pkg::POS_W'(mag_x64);
      end
      if (it_pos_y_ff) begin
         lat_y = (mag_y64 > dms_pkg::NEG_MAG_LIMIT) ? dms_pkg::POS_MOST_NEG
                 : dms_pkg::POS_W'(64'd0 - mag_y64);
      end else begin
         lat_y = (mag_y64 > dms_pkg::POS_MAG_LIMIT) ? dms_pkg::POS_MOST_POS
                 : dms_pkg::POS_W'(mag_y64);
      end
      dep_z = (mag_z64 > dms_pkg::NEG_MAG_LIMIT) ? dms_pkg::POS_MOST_NEG
              : dms_pkg::POS_W'(64'd0 - mag_z64);
   end

   always_ff @(posedge clock) begin
      if (state_ff == dms_pkg::BK_SUM) begin
         cur_ff[0] <= lat_x;
         cur_ff[1] <= lat_y;
         cur_ff[2] <= dep_z;
      end
   end

   // Neighbor corners: the up-left and left vertices of the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         ul_ok_ff <= 1'b0;
         lf_ok_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            ul_ff[k] <= '0;
            lf_ff[k] <= '0;
         end
      end else if (item_done) begin
         ul_ok_ff <= up_ok;
         lf_ok_ff <= it_ok_ff;
         for (int k = 0; k < 3; k++) begin
            ul_ff[k] <= up[k];
            lf_ff[k] <= cur_ff[k];
         end
      end
   end

   // Edge pipeline: absolute differences, squares, then sum and compare.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (edge_cnt_ff)
            dms_pkg::EDGE_UL_UP: begin
               ep[k] = ul_ff[k];
               eq[k] = up[k];
            end
            dms_pkg::EDGE_UL_LF: begin
               ep[k] = ul_ff[k];
               eq[k] = lf_ff[k];
            end
            dms_pkg::EDGE_UP_LF: begin
               ep[k] = up[k];
               eq[k] = lf_ff[k];
            end
            dms_pkg::EDGE_UP_CUR: begin
               ep[k] = up[k];
               eq[k] = cur_ff[k];
            end
            default: begin
               ep[k] = lf_ff[k];
               eq[k] = cur_ff[k];
            end
         endcase
      end
   end

   assign limit    = dms_pkg::SQ_W'(cfg.edge_limit_squared) << LIM_SH;
   assign edge_sum = (dms_pkg::SQ_W+2)'(e2_sq_ff[0]) + (dms_pkg::SQ_W+2)'(e2_sq_ff[1])
                     + (dms_pkg::SQ_W+2)'(e2_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
      end else begin
         e1_v_ff <= edge_issue;
         e2_v_ff <= e1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [dms_pkg::POS_W:0] diff;
      for (int k = 0; k < 3; k++) begin
         diff = {ep[k][dms_pkg::POS_W-1], ep[k]} - {eq[k][dms_pkg::POS_W-1], eq[k]};
         if (edge_issue) begin
            e1_ad_ff[k] <= diff[dms_pkg::POS_W] ? dms_pkg::POS_W'(-diff)
                           : diff[dms_pkg::POS_W-1:0];
         end
         e2_sq_ff[k] <= e1_ad_ff[k] * e1_ad_ff[k];
      end
      e1_id_ff <= edge_cnt_ff;
      e2_id_ff <= e1_id_ff;
      if (e2_v_ff) begin
         good_ff[e2_id_ff] <= edge_sum < (dms_pkg::SQ_W+2)'(limit);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (state_ff == dms_pkg::BK_VERTEX) begin
            rsp_kind_ff <= dms_pkg::KIND_VERTEX;
            rsp_ok_ff   <= it_ok_ff;
            rsp_pos_ff  <= cur_ff;
            rsp_rgb_ff  <= it_rgb_ff;
            rsp_a_ff    <= it_idx_ff;
            rsp_b_ff    <= '0;
            rsp_c_ff    <= '0;
            rsp_last_ff <= ~(face_a | face_b);
         end else begin
            rsp_kind_ff <= dms_pkg::KIND_FACE;
            rsp_ok_ff   <= 1'b1;
            for (int k = 0; k < 3; k++) begin
               rsp_pos_ff[k] <= '0;
            end
            rsp_rgb_ff <= '0;
            rsp_c_ff   <= it_ic_ff;
            if (state_ff == dms_pkg::BK_FACE_A) begin
               rsp_a_ff    <= it_ia_ff;
               rsp_b_ff    <= it_ib_ff;
               rsp_last_ff <= ~face_b;
            end else begin
               rsp_a_ff    <= it_ib_ff;
               rsp_b_ff    <= it_idx_ff;
               rsp_last_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.vertex_ok   = rsp_ok_ff;
   assign rsp_bus.pos_x       = rsp_pos_ff[0];
   assign rsp_bus.pos_y       = rsp_pos_ff[1];
   assign rsp_bus.pos_z       = rsp_pos_ff[2];
   assign rsp_bus.out_red     = rsp_rgb_ff[3*dms_pkg::COLOR_W-1:2*dms_pkg::COLOR_W];
   assign rsp_bus.out_green   = rsp_rgb_ff[2*dms_pkg::COLOR_W-1:dms_pkg::COLOR_W];
   assign rsp_bus.out_blue    = rsp_rgb_ff[dms_pkg::COLOR_W-1:0];
   assign rsp_bus.corner_a    = rsp_a_ff;
   assign rsp_bus.corner_b    = rsp_b_ff;
   assign rsp_bus.corner_c    = rsp_c_ff;
   assign rsp_bus.last_result = rsp_last_ff;

endmodule

FILE: hdl/depth_to_mesh_stream_unit.sv
// Channel   Direction  Words carried
// req_bus   in         one pixel: raw depth and red, green, blue
// rsp_bus   out        one vertex, then up to two faces of the cell it closes
// csr_*     in         register writes, index and data, no read-back
//
// In the back sequencer a pixel is taken from the queue, goes through four multiply steps,
// the last two through the two lane multipliers, then through the edge-length pipeline and
// then one result slot each (vertex, first face, second face); a result waits for rsp_bus.
// The front takes a pixel in the cycle it arrives while the two-word queue has room.
// Reset is synchronous; it clears the raster counters, the queue, the sequencer, the
// neighbor registers and the result register, and loads the register defaults. The
// row store is not cleared and needs no clearing pass.
module depth_to_mesh_stream_unit #(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_HEIGHT      = 1024,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   dms_req_if.sink                           req_bus,
   dms_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [dms_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dms_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int MAG_W0 = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
   localparam int MAG_W  = MAG_W0 > dms_pkg::CENTER_W ? MAG_W0 : dms_pkg::CENTER_W;
   localparam int ITEM_W = dms_pkg::DEPTH_W + 3 * dms_pkg::COLOR_W + COL_W
                           + 2 * (MAG_W + 1) + 4 * dms_pkg::INDEX_W + 1;

   dms_pkg::cfg_type cfg_ff, cfg_in;

   logic              push, queue_full, queue_pop, queue_valid;
   logic [ITEM_W-1:0] push_data, queue_head;

   // Register file. Each write replaces one field; the field keeps its low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (dms_pkg::csr_index_type'(csr_index))
            dms_pkg::CSR_DEPTH_UNIT:    cfg_in.depth_unit    = csr_wdata[23:0];
            dms_pkg::CSR_FOCAL_X_RECIP: cfg_in.focal_x_recip = csr_wdata[23:0];
            dms_pkg::CSR_FOCAL_Y_RECIP: cfg_in.focal_y_recip = csr_wdata[23:0];
            dms_pkg::CSR_CENTER_X:      cfg_in.center_x      = csr_wdata[10:0];
            dms_pkg::CSR_CENTER_Y:      cfg_in.center_y      = csr_wdata[10:0];
            dms_pkg::CSR_EDGE_LIMIT:    cfg_in.edge_limit_squared = csr_wdata;
            dms_pkg::CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[10:0];
            dms_pkg::CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dms_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front tracks the raster position and works out indices and pixel offsets.
   dms_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // The queue lets the front keep taking pixels while the back is busy.
   dms_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .head      (queue_head)
   );

   // The back projects the vertex, checks the cell edges and sends the results.
   dms_back #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
